[hw/rtl/differential_drive_odometry_top_defines.svh]
// ----------------------------------------------------------------------------
// Odometry assertion macros
// Shared concurrent assertion forms for the odometry RTL.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_TOP_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DDO_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("odometry assertion failed (same-cycle implication)");

// Next-cycle implication, disabled while reset is high.
`define DDO_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("odometry assertion failed (next-cycle implication)");

`endif

[hw/rtl/ddo_pkg.sv]
// ----------------------------------------------------------------------------
// Odometry package
// Widths, register codes, sequencer states and helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ddo_pkg;

  localparam int TICK_W    = 16;
  localparam int SUM_W     = 17;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int POS_W     = 48;
  localparam int HEAD_W    = 32;

  localparam int MUL_W  = 32;
  localparam int MUL_PW = 64;
  localparam int MD_W   = 49;
  localparam int HIP_W  = 48;
  localparam int MAG_W  = 50;
  localparam int TRIG_W = 31;
  localparam int ACC_W  = 51;

  localparam int CORDIC_ITERS = 30;
  localparam int ITER_W       = 5;
  localparam int CW           = 33;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [31:0]   Q30_POS     = 32'sh4000_0000;
  localparam logic signed [31:0]   Q30_NEG     = -32'sh4000_0000;
  localparam logic [TRIG_W-1:0]    TRIG_ONE    = 31'h4000_0000;
  localparam logic [HEAD_W-1:0]    QUARTER_HALF = 32'h2000_0000;
  localparam logic [MUL_PW-1:0]    ROUND_HALF  = 64'h0000_0000_4000_0000;

  localparam logic [CFG_W-1:0] MPT_RESET = 32'd2525435;
  localparam logic [CFG_W-1:0] HPT_RESET = 32'd3721624;

  localparam logic signed [ACC_W-1:0] POS_MAX_EXT =
    {{(ACC_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] POS_MIN_EXT =
    {{(ACC_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_METRES_PER_TICK  = 1'b0,
    CFG_HEADING_PER_TICK = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_ROT,
    ST_MD,
    ST_TURN,
    ST_XLO,
    ST_XHI,
    ST_YLO,
    ST_YHI,
    ST_YMAG,
    ST_YACC,
    ST_FINISH
  } state_t;

  // Rotation angle of each CORDIC iteration, 2^32 per turn, rounded.
  function automatic logic [31:0] atan_turn(input logic [ITER_W-1:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:    a = 32'h2000_0000;
      5'd1:    a = 32'h12E4_051E;
      5'd2:    a = 32'h09FB_385B;
      5'd3:    a = 32'h0511_11D4;
      5'd4:    a = 32'h028B_0D43;
      5'd5:    a = 32'h0145_D7E1;
      5'd6:    a = 32'h00A2_F61E;
      5'd7:    a = 32'h0051_7C55;
      5'd8:    a = 32'h0028_BE53;
      5'd9:    a = 32'h0014_5F2F;
      5'd10:   a = 32'h000A_2F98;
      5'd11:   a = 32'h0005_17CC;
      5'd12:   a = 32'h0002_8BE6;
      5'd13:   a = 32'h0001_45F3;
      5'd14:   a = 32'h0000_A2FA;
      5'd15:   a = 32'h0000_517D;
      5'd16:   a = 32'h0000_28BE;
      5'd17:   a = 32'h0000_145F;
      5'd18:   a = 32'h0000_0A30;
      5'd19:   a = 32'h0000_0518;
      5'd20:   a = 32'h0000_028C;
      5'd21:   a = 32'h0000_0146;
      5'd22:   a = 32'h0000_00A3;
      5'd23:   a = 32'h0000_0051;
      5'd24:   a = 32'h0000_0029;
      5'd25:   a = 32'h0000_0014;
      5'd26:   a = 32'h0000_000A;
      5'd27:   a = 32'h0000_0005;
      5'd28:   a = 32'h0000_0003;
      5'd29:   a = 32'h0000_0001;
      default: a = 32'h0000_0000;
    endcase
    return a;
  endfunction

  // Clamp a widened position sum to the signed position range.
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ACC_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > POS_MAX_EXT) begin
      r = POS_MAX_EXT[POS_W-1:0];
    end else if (v < POS_MIN_EXT) begin
      r = POS_MIN_EXT[POS_W-1:0];
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/ddo_mul.sv]
// ----------------------------------------------------------------------------
// Odometry multiplier
// Unsigned 32 by 32 multiplier with a registered product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddo_mul (
  input  logic                       clk,
  input  logic [ddo_pkg::MUL_W-1:0]  a,
  input  logic [ddo_pkg::MUL_W-1:0]  b,
  output logic [ddo_pkg::MUL_PW-1:0] p
);
  import ddo_pkg::*;

  // The product is registered and ready in the cycle after the operands are presented.
  always_ff @(posedge clk) begin
    p <= MUL_PW'(a) * MUL_PW'(b);
  end

endmodule

[hw/rtl/differential_drive_odometry_top.sv]
// ----------------------------------------------------------------------------
// Differential-drive wheel odometry
// Each input transaction carries signed left and right tick counts; each one
// yields one output transaction with the new x, y (2^-32 m) and heading
// (2^32 per turn). Both channels use valid/stall. Two config registers
// (metres_per_tick, heading_per_tick) are written through cfg_write,
// cfg_index and cfg_data. The user must write them only while the block is
// idle; the block itself does not enforce this.
// An item runs through the 30-step CORDIC loop on the shared add/shift
// unit, then sequenced work on one 32x32 multiplier (six products, two
// rounding adds and two saturating adds), then the load of the output
// register. A new item is accepted only after the last one is loaded.
// A finished result waits in the output register while the next item is
// accepted; if the receiver still stalls when that item is done, the block
// holds it and keeps in_stall high until the output register frees up.
// Synchronous reset clears the pose to zero, loads the register defaults
// and empties the output register; in_stall is high during reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "differential_drive_odometry_top_defines.svh"

module differential_drive_odometry_top (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration
  input  logic                                cfg_write,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ddo_pkg::CFG_W-1:0]           cfg_data,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ddo_pkg::TICK_W-1:0]   left_ticks,
  input  logic signed [ddo_pkg::TICK_W-1:0]   right_ticks,
  // Output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ddo_pkg::POS_W-1:0]    pos_x,
  output logic signed [ddo_pkg::POS_W-1:0]    pos_y,
  output logic [ddo_pkg::HEAD_W-1:0]          heading_angle
);
  import ddo_pkg::*;

  state_t state, state_next;

  // Configuration registers.
  logic [CFG_W-1:0] metres_per_tick;
  logic [CFG_W-1:0] heading_per_tick;

  // Pose accumulators.
  logic signed [POS_W-1:0] x_acc;
  logic signed [POS_W-1:0] y_acc;
  logic [HEAD_W-1:0]       heading_acc;

  // Per-transaction operands.
  logic [SUM_W-1:0]        sum_mag;
  logic                    sum_neg;
  logic signed [SUM_W-1:0] diff;

  // CORDIC registers.
  logic signed [CW-1:0] cx, cy, cz;
  logic [ITER_W-1:0]    iter;
  logic [1:0]           quad;

  // Trig results as magnitude and sign.
  logic [TRIG_W-1:0] cos_mag, sin_mag;
  logic              cos_neg, sin_neg;

  // Multiply and accumulate datapath.
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [MUL_PW-1:0] mul_p;
  logic [MD_W-1:0]   md;
  logic [MUL_PW-2:0] plo;
  logic [MAG_W-1:0]  mag;

  logic in_accept;
  logic out_load;

  // --------------------------------------------------------------------------
  // Input-side arithmetic: tick sum and difference are exact in 17 bits.
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0] sum_in, diff_in;

  assign sum_in  = {left_ticks[TICK_W-1], left_ticks} + {right_ticks[TICK_W-1], right_ticks};
  assign diff_in = {right_ticks[TICK_W-1], right_ticks} - {left_ticks[TICK_W-1], left_ticks};

  assign in_stall  = rst || (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // Quadrant reduction: nearest quarter turn, residual in [-1/8, 1/8) turn.
  logic [HEAD_W-1:0] head_shift, head_res;
  logic [1:0]        quad_in;

  assign head_shift = heading_acc + QUARTER_HALF;
  assign quad_in    = head_shift[HEAD_W-1:HEAD_W-2];
  assign head_res   = heading_acc - {quad_in, {(HEAD_W-2){1'b0}}};

  // --------------------------------------------------------------------------
  // CORDIC micro-rotation: arithmetic shifts give floor division by 2^i.
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] xs, ys, atan_ext;
  logic signed [CW-1:0] cx_step, cy_step, cz_step;

  assign xs       = cx >>> iter;
  assign ys       = cy >>> iter;
  assign atan_ext = $signed({1'b0, atan_turn(iter)});

  always_comb begin
    if (!cz[CW-1]) begin
      cx_step = cx - ys;
      cy_step = cy + xs;
      cz_step = cz - atan_ext;
    end else begin
      cx_step = cx + ys;
      cy_step = cy - xs;
      cz_step = cz + atan_ext;
    end
  end

  // Clamp to the Q1.30 unit range and split into magnitude and sign.
  logic signed [31:0] cx_cl, cy_cl, cx_abs, cy_abs;

  always_comb begin
    if (cx > CW'(Q30_POS)) begin
      cx_cl = Q30_POS;
    end else if (cx < CW'(Q30_NEG)) begin
      cx_cl = Q30_NEG;
    end else begin
      cx_cl = cx[31:0];
    end
    if (cy > CW'(Q30_POS)) begin
      cy_cl = Q30_POS;
    end else if (cy < CW'(Q30_NEG)) begin
      cy_cl = Q30_NEG;
    end else begin
      cy_cl = cy[31:0];
    end
    cx_abs = cx_cl[31] ? -cx_cl : cx_cl;
    cy_abs = cy_cl[31] ? -cy_cl : cy_cl;
  end

  // --------------------------------------------------------------------------
  // Rounding add: (hi * t) * 2 + round(lo * t / 2^31). Together that is the
  // product md * t / 2^31 rounded to nearest, halves away from zero.
  // --------------------------------------------------------------------------
  logic [MUL_PW-1:0] plo_rnd;
  logic [MAG_W-1:0]  mag_next;

  assign plo_rnd  = {1'b0, plo} + ROUND_HALF;
  assign mag_next = MAG_W'({mul_p[HIP_W-1:0], 1'b0}) + MAG_W'(plo_rnd[MUL_PW-1:31]);

  // Saturating accumulate, shared between x and y.
  logic signed [POS_W-1:0] acc_in, acc_sat;
  logic                    acc_neg;
  logic signed [ACC_W-1:0] acc_step, acc_sum;

  always_comb begin
    if (state == ST_YACC) begin
      acc_in  = y_acc;
      acc_neg = sum_neg ^ sin_neg;
    end else begin
      acc_in  = x_acc;
      acc_neg = sum_neg ^ cos_neg;
    end
    acc_step = acc_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    acc_sum  = $signed({{(ACC_W-POS_W){acc_in[POS_W-1]}}, acc_in}) + acc_step;
    acc_sat  = sat_pos(acc_sum);
  end

  // --------------------------------------------------------------------------
  // Shared multiplier.
  // --------------------------------------------------------------------------
  ddo_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // --------------------------------------------------------------------------
  // Sequencer: next state and multiplier operands.
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_CORDIC;
        end
      end
      ST_CORDIC: begin
        if (iter == ITER_W'(CORDIC_ITERS - 1)) begin
          state_next = ST_ROT;
        end
      end
      ST_ROT: begin
        state_next = ST_MD;
      end
      ST_MD: begin
        mul_a      = MUL_W'(sum_mag);
        mul_b      = metres_per_tick;
        state_next = ST_TURN;
      end
      ST_TURN: begin
        mul_a      = {{(MUL_W-SUM_W){diff[SUM_W-1]}}, diff};
        mul_b      = heading_per_tick;
        state_next = ST_XLO;
      end
      ST_XLO: begin
        mul_a      = md[MUL_W-1:0];
        mul_b      = MUL_W'(cos_mag);
        state_next = ST_XHI;
      end
      ST_XHI: begin
        mul_a      = MUL_W'(md[MD_W-1:MUL_W]);
        mul_b      = MUL_W'(cos_mag);
        state_next = ST_YLO;
      end
      ST_YLO: begin
        mul_a      = md[MUL_W-1:0];
        mul_b      = MUL_W'(sin_mag);
        state_next = ST_YHI;
      end
      ST_YHI: begin
        mul_a      = MUL_W'(md[MD_W-1:MUL_W]);
        mul_b      = MUL_W'(sin_mag);
        state_next = ST_YMAG;
      end
      ST_YMAG: begin
        state_next = ST_YACC;
      end
      ST_YACC: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      metres_per_tick  <= MPT_RESET;
      heading_per_tick <= HPT_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        CFG_METRES_PER_TICK:  metres_per_tick  <= cfg_data;
        CFG_HEADING_PER_TICK: heading_per_tick <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pose state and output register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      x_acc       <= '0;
      y_acc       <= '0;
      heading_acc <= '0;
      out_valid   <= 1'b0;
    end else begin
      // The heading used for this step's motion is captured before it moves.
      if (state == ST_XLO) begin
        heading_acc <= heading_acc + mul_p[HEAD_W-1:0];
      end
      if (state == ST_YHI) begin
        x_acc <= acc_sat;
      end
      if (state == ST_YACC) begin
        y_acc <= acc_sat;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pos_x         <= x_acc;
      pos_y         <= y_acc;
      heading_angle <= heading_acc;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers of the transaction in flight.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      iter <= '0;
    end else if (state == ST_IDLE) begin
      iter <= '0;
    end else if (state == ST_CORDIC) begin
      iter <= iter + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          sum_mag <= sum_in[SUM_W-1] ? SUM_W'(-sum_in) : SUM_W'(sum_in);
          sum_neg <= sum_in[SUM_W-1];
          diff    <= diff_in;
          quad    <= quad_in;
          cx      <= CORDIC_GAIN;
          cy      <= '0;
          cz      <= $signed({head_res[HEAD_W-1], head_res});
        end
      end
      ST_CORDIC: begin
        cx <= cx_step;
        cy <= cy_step;
        cz <= cz_step;
      end
      ST_ROT: begin
        // Quarter-turn rotation swaps and negates the CORDIC outputs.
        if (!quad[0]) begin
          cos_mag <= cx_abs[TRIG_W-1:0];
          sin_mag <= cy_abs[TRIG_W-1:0];
        end else begin
          cos_mag <= cy_abs[TRIG_W-1:0];
          sin_mag <= cx_abs[TRIG_W-1:0];
        end
        case (quad)
          2'd0: begin
            cos_neg <= cx_cl[31];
            sin_neg <= cy_cl[31];
          end
          2'd1: begin
            cos_neg <= !cy_cl[31];
            sin_neg <= cx_cl[31];
          end
          2'd2: begin
            cos_neg <= !cx_cl[31];
            sin_neg <= !cy_cl[31];
          end
          default: begin
            cos_neg <= cy_cl[31];
            sin_neg <= !cx_cl[31];
          end
        endcase
      end
      ST_TURN: begin
        md <= mul_p[MD_W-1:0];
      end
      ST_XHI, ST_YHI: begin
        plo <= mul_p[MUL_PW-2:0];
      end
      ST_YLO, ST_YMAG: begin
        mag <= mag_next;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `DDO_ASSERT_NXT(a_accept_starts_cordic, clk, rst, in_valid && !in_stall, state == ST_CORDIC && iter == '0)
  `DDO_ASSERT_IMP(a_iter_in_range, clk, rst, state == ST_CORDIC, iter < ITER_W'(CORDIC_ITERS))
  `DDO_ASSERT_IMP(a_trig_unit_range, clk, rst, state == ST_MD, cos_mag <= TRIG_ONE && sin_mag <= TRIG_ONE)
  `DDO_ASSERT_IMP(a_out_after_finish, clk, rst, $rose(out_valid), $past(state) == ST_FINISH)
  `DDO_ASSERT_IMP(a_heading_only_in_xlo, clk, rst, $past(state) != ST_XLO && !$past(rst), $stable(heading_acc))

endmodule
